// ===== rtl/core/bmpw_pkg.sv =====
// bmpw_pkg: shared widths, header layout constants and helper functions
// for the 24-bit BMP stream writer. Depends on nothing.

package bmpw_pkg;

    localparam int VAL_W = 17;              // Q1.16 intensity
    localparam int DIM_W = 13;              // image dimension register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ROWB_W = 15;             // padded bytes per row
    localparam int IDX_W = 6;               // byte position within one job
    localparam int SIZE_W = 32;
    localparam int MAX_DIMENSION_DEF = 4096;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    // Header byte positions and values
    localparam logic [IDX_W-1:0] OFS_MAGIC_B = 6'd0;
    localparam logic [IDX_W-1:0] OFS_MAGIC_M = 6'd1;
    localparam logic [IDX_W-1:0] OFS_SIZE    = 6'd2;
    localparam logic [IDX_W-1:0] OFS_OFFSET  = 6'd10;
    localparam logic [IDX_W-1:0] OFS_INFO    = 6'd14;
    localparam logic [IDX_W-1:0] OFS_WIDTH   = 6'd18;
    localparam logic [IDX_W-1:0] OFS_HEIGHT  = 6'd22;
    localparam logic [IDX_W-1:0] OFS_PLANES  = 6'd26;
    localparam logic [IDX_W-1:0] OFS_BPP     = 6'd28;
    localparam logic [IDX_W-1:0] HDR_LEN     = 6'd54;
    localparam logic [IDX_W-1:0] IDX_BLUE    = 6'd54;
    localparam logic [IDX_W-1:0] IDX_GREEN   = 6'd55;
    localparam logic [IDX_W-1:0] IDX_RED     = 6'd56;

    localparam logic [7:0] CHAR_B   = 8'h42;
    localparam logic [7:0] CHAR_M   = 8'h4D;
    localparam logic [7:0] INFO_LEN = 8'd40;
    localparam logic [7:0] PLANES   = 8'd1;
    localparam logic [7:0] BPP      = 8'd24;

    typedef struct packed {
        logic              hdr;
        logic [7:0]        blue_b;
        logic [7:0]        green_b;
        logic [7:0]        red_b;
        logic [1:0]        pad;
        logic              frame_end;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [SIZE_W-1:0] size;
    } job_t;

    // floor(v*255/65536), saturated; v*255 done as (v<<8)-v
    function automatic logic [7:0] to_byte(input logic [VAL_W-1:0] v);
        logic [VAL_W+7:0] p;
        logic [8:0]       q;
        p = {v, 8'd0} - {8'd0, v};
        q = p[VAL_W+7:16];
        return (q > 9'd255) ? 8'hFF : q[7:0];
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [DIM_W-1:0] w,
                                           input logic [DIM_W-1:0] h);
        logic [7:0] b;
        b = 8'd0;
        case (idx)
            OFS_MAGIC_B:         b = CHAR_B;
            OFS_MAGIC_M:         b = CHAR_M;
            OFS_SIZE:            b = size[7:0];
            OFS_SIZE + 6'd1:     b = size[15:8];
            OFS_SIZE + 6'd2:     b = size[23:16];
            OFS_SIZE + 6'd3:     b = size[31:24];
            OFS_OFFSET:          b = 8'(HDR_LEN);
            OFS_INFO:            b = INFO_LEN;
            OFS_WIDTH:           b = w[7:0];
            OFS_WIDTH + 6'd1:    b = 8'(w[DIM_W-1:8]);
            OFS_HEIGHT:          b = h[7:0];
            OFS_HEIGHT + 6'd1:   b = 8'(h[DIM_W-1:8]);
            OFS_PLANES:          b = PLANES;
            OFS_BPP:             b = BPP;
            default:             b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/bmpw_if.sv =====
// bmpw_if: valid/ready channel interfaces for pixels, output bytes and
// configuration writes. Depends on bmpw_pkg.

interface bmpw_pix_if;
    logic                       valid;
    logic                       ready;
    logic [bmpw_pkg::VAL_W-1:0] red;
    logic [bmpw_pkg::VAL_W-1:0] green;
    logic [bmpw_pkg::VAL_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bmpw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_of_run;
    logic       end_of_image;

    modport source (output valid, byte_value, last_of_run, end_of_image, input ready);
    modport sink   (input valid, byte_value, last_of_run, end_of_image, output ready);
endinterface

interface bmpw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmpw_pkg::CFG_IDX_W-1:0]  index;
    logic [bmpw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bmpw_front.sv =====
// bmpw_front: configuration registers, raster counters and color conversion.
// Builds one job per accepted pixel. Depends on bmpw_pkg and bmpw_if.

module bmpw_front #(
    parameter int MAX_DIMENSION = bmpw_pkg::MAX_DIMENSION_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bmpw_pix_if.sink          pixels,
    bmpw_cfg_if.sink          cfg,
    input  logic              full,
    output logic              push,
    output bmpw_pkg::job_t    job
);

    localparam int DW = bmpw_pkg::DIM_W;
    localparam int RW = bmpw_pkg::ROWB_W;

    logic [DW-1:0] w_reg, w_next, h_reg, h_next;
    logic [RW-1:0] row_bytes_reg, row_bytes_next;
    logic [1:0]    pad_reg, pad_next;
    logic [DW-1:0] col_reg, col_next, row_reg, row_next;

    logic [DW-1:0]   cfg_dim;
    logic [RW-1:0]   triple;
    logic [1:0]      cfg_pad;
    logic            accept;
    logic [DW:0]     col_inc, row_inc;
    logic            row_end, frame_end;
    logic [DW+RW-1:0] prod;

    assign cfg.ready = 1'b1;

    // clamp written dimension into 1..MAX_DIMENSION
    always_comb
    begin
        if (cfg.data == '0)
            cfg_dim = DW'(1);
        else if (32'(cfg.data) > 32'(MAX_DIMENSION))
            cfg_dim = DW'(MAX_DIMENSION);
        else
            cfg_dim = cfg.data;
        triple  = RW'({cfg_dim, 1'b0}) + RW'(cfg_dim);
        cfg_pad = ~triple[1:0] + 2'd1;
    end

    always_comb
    begin
        w_next         = w_reg;
        h_next         = h_reg;
        row_bytes_next = row_bytes_reg;
        pad_next       = pad_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bmpw_pkg::CFG_WIDTH:
                begin
                    w_next         = cfg_dim;
                    pad_next       = cfg_pad;
                    row_bytes_next = triple + RW'(cfg_pad);
                end
                bmpw_pkg::CFG_HEIGHT: h_next = cfg_dim;
                default: ;
            endcase
        end
    end

    assign pixels.ready = !full;
    assign accept       = pixels.valid && !full;
    assign push         = accept;

    // counts may exceed a newly written size; >= ends the row or frame
    assign col_inc   = {1'b0, col_reg} + (DW+1)'(1);
    assign row_inc   = {1'b0, row_reg} + (DW+1)'(1);
    assign row_end   = col_inc >= {1'b0, w_reg};
    assign frame_end = row_end && (row_inc >= {1'b0, h_reg});

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[DW-1:0];
            end
            else
            begin
                col_next = col_inc[DW-1:0];
            end
        end
    end

    assign prod = (DW+RW)'(row_bytes_reg) * (DW+RW)'(h_reg);

    always_comb
    begin
        job.hdr       = (col_reg == '0) && (row_reg == '0);
        job.blue_b    = bmpw_pkg::to_byte(pixels.blue);
        job.green_b   = bmpw_pkg::to_byte(pixels.green);
        job.red_b     = bmpw_pkg::to_byte(pixels.red);
        job.pad       = row_end ? pad_reg : 2'd0;
        job.frame_end = frame_end;
        job.w         = w_reg;
        job.h         = h_reg;
        job.size      = bmpw_pkg::SIZE_W'(prod) + bmpw_pkg::SIZE_W'(bmpw_pkg::HDR_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= DW'(1);
            h_reg         <= DW'(1);
            row_bytes_reg <= RW'(4);
            pad_reg       <= 2'd1;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            row_bytes_reg <= row_bytes_next;
            pad_reg       <= pad_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // padded row length stays a multiple of four covering three bytes a pixel
    a_row_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        row_bytes_reg[1:0] == 2'd0 &&
        row_bytes_reg == RW'({w_reg, 1'b0}) + RW'(w_reg) + RW'(pad_reg))
        else $error("row byte count inconsistent with width");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared after frame end");

endmodule

// ===== rtl/core/bmpw_queue.sv =====
// bmpw_queue: two-entry job queue between front and back.
// Depends on bmpw_pkg.

module bmpw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bmpw_pkg::job_t push_job,
    input  logic           pop,
    output bmpw_pkg::job_t head,
    output logic           full,
    output logic           empty
);

    bmpw_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/bmpw_back.sv =====
// bmpw_back: byte sequencer. Walks one job through header, pixel and
// padding bytes into a registered output stage. Depends on bmpw_pkg, bmpw_if.

module bmpw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bmpw_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    bmpw_byte_if.source    stream
);

    localparam int IW = bmpw_pkg::IDX_W;

    logic [IW-1:0] idx_reg, idx_next;
    logic          started_reg, started_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg, out_eoi_reg;

    logic          emit;
    logic [IW-1:0] cur_idx, last_idx;
    logic          is_last;
    logic [7:0]    cur_byte;

    assign emit     = !empty && (!out_valid_reg || stream.ready);
    assign cur_idx  = started_reg ? idx_reg : (head.hdr ? '0 : bmpw_pkg::HDR_LEN);
    assign last_idx = bmpw_pkg::IDX_RED + IW'(head.pad);
    assign is_last  = cur_idx == last_idx;
    assign pop      = emit && is_last;

    always_comb
    begin
        if (cur_idx < bmpw_pkg::HDR_LEN)
            cur_byte = bmpw_pkg::hdr_byte(cur_idx, head.size, head.w, head.h);
        else if (cur_idx == bmpw_pkg::IDX_BLUE)
            cur_byte = head.blue_b;
        else if (cur_idx == bmpw_pkg::IDX_GREEN)
            cur_byte = head.green_b;
        else if (cur_idx == bmpw_pkg::IDX_RED)
            cur_byte = head.red_b;
        else
            cur_byte = 8'd0;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            started_next   = !is_last;
            idx_next       = cur_idx + IW'(1);
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
            out_eoi_reg  <= is_last && head.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stream.valid        = out_valid_reg;
    assign stream.byte_value   = out_byte_reg;
    assign stream.last_of_run  = out_last_reg;
    assign stream.end_of_image = out_eoi_reg;

    a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        stream.valid && stream.end_of_image |-> stream.last_of_run)
        else $error("end of image without end of run");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> cur_idx <= last_idx)
        else $error("byte index ran past end of job");

    a_started_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> !empty)
        else $error("job in progress with empty queue");

endmodule

// ===== rtl/core/bmp24_stream_writer.sv =====
// bmp24_stream_writer: top level of the 24-bit BMP stream encoder.
// Depends on bmpw_pkg, bmpw_if, bmpw_front, bmpw_queue, bmpw_back.
//
//   channel   modport  payload                                   accepted when
//   pixels    sink     red, green, blue (17b Q1.16 each)         valid && ready
//   stream    source   byte_value, last_of_run, end_of_image     valid && ready
//   cfg       sink     index (0 width, 1 height), data (13b)     valid (ready tied 1)
//
// One output byte per cycle while jobs are queued and stream.ready is high:
// 3 to 6 bytes per pixel, 57 to 60 for the pixel that opens a frame; the byte
// sequencer and its output register set the rate. An accepted pixel's job is
// written to the queue, then its first byte goes to the output register. The
// two-entry job queue holds up to two pixels' jobs while the byte side stalls.
// Reset sets width and height to 1 and clears the raster counters.

module bmp24_stream_writer #(
    parameter int MAX_DIMENSION = bmpw_pkg::MAX_DIMENSION_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmpw_pix_if.sink    pixels,
    bmpw_byte_if.source stream,
    bmpw_cfg_if.sink    cfg
);

    bmpw_pkg::job_t push_job, head;
    logic           push, pop, full, empty;

    bmpw_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .cfg    (cfg),
        .full   (full),
        .push   (push),
        .job    (push_job)
    );

    bmpw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    bmpw_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .stream (stream)
    );

endmodule

// ===== bench/bmpw_stream_checker.sv =====
// bmpw_stream_checker: watches the pixel, byte and register channels of the
// BMP stream writer, predicts every output byte and compares in order.
// Depends on bmpw_pkg and bmpw_if.

module bmpw_stream_checker (
    input  logic clk,
    input  logic rst_n,
    bmpw_pix_if  pixels,
    bmpw_byte_if stream,
    bmpw_cfg_if  cfg,
    output int   mismatches,
    output int   bytes_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import bmpw_pkg::*;

    localparam int HEADER_LEN = 54;
    localparam int INFO_SIZE  = 40;

    typedef struct {
        logic [7:0] value;
        logic       last_of_run;
        logic       end_of_image;
    } bmp_byte_t;

    bmp_byte_t        due_q[$];
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    int unsigned      cols_done;
    int unsigned      rows_done;
    int               fail_count = 0;
    int               due_count = 0;

    assign mismatches = fail_count;
    assign bytes_due  = due_count;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIMENSION_DEF)
            return MAX_DIMENSION_DEF;
        return v;
    endfunction

    // floor(v*255/65536), saturating above full scale
    function automatic logic [7:0] intensity_byte(input logic [VAL_W-1:0] v);
        int unsigned q;
        q = (int'(v) * 255) >> 16;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic encode_pixel(input logic [VAL_W-1:0] r, input logic [VAL_W-1:0] g,
                                input logic [VAL_W-1:0] b);
        logic [7:0]  burst [60];
        int          n;
        int          i;
        int unsigned w;
        int unsigned h;
        int unsigned pad;
        logic [31:0] size;
        bit          frame_end;
        bmp_byte_t   item;
        w = clamp_dim(reg_width);
        h = clamp_dim(reg_height);
        pad = (4 - (w * 3) % 4) % 4;
        n = 0;
        frame_end = 1'b0;
        if (cols_done == 0 && rows_done == 0)
        begin
            // w, h <= 4096 so the size never wraps
            size = 32'(HEADER_LEN + (w * 3 + pad) * h);
            for (i = 0; i < HEADER_LEN; i++)
                burst[i] = 8'h00;
            burst[0] = 8'h42;
            burst[1] = 8'h4D;
            for (i = 0; i < 4; i++)
            begin
                burst[2 + i]  = 8'(size >> (8 * i));
                burst[10 + i] = 8'(HEADER_LEN >> (8 * i));
                burst[14 + i] = 8'(INFO_SIZE >> (8 * i));
                burst[18 + i] = 8'(w >> (8 * i));
                burst[22 + i] = 8'(h >> (8 * i));
            end
            burst[26] = 8'd1;
            burst[28] = 8'd24;
            n = HEADER_LEN;
        end
        burst[n]     = intensity_byte(b);
        burst[n + 1] = intensity_byte(g);
        burst[n + 2] = intensity_byte(r);
        n = n + 3;
        if (cols_done + 1 >= w)
        begin
            for (i = 0; i < pad; i++)
                burst[n + i] = 8'h00;
            n = n + pad;
            cols_done = 0;
            if (rows_done + 1 >= h)
            begin
                frame_end = 1'b1;
                rows_done = 0;
            end
            else
                rows_done++;
        end
        else
            cols_done++;
        for (i = 0; i < n; i++)
        begin
            item.value        = burst[i];
            item.last_of_run  = (i == n - 1);
            item.end_of_image = (i == n - 1) && frame_end;
            due_q.push_back(item);
        end
    endtask

    task automatic check_byte();
        bmp_byte_t want;
        if (due_q.size() == 0)
        begin
            report_mismatch("byte with nothing due", stream.byte_value, -1);
            return;
        end
        want = due_q.pop_front();
        if (stream.byte_value !== want.value)
            report_mismatch("byte_value", stream.byte_value, want.value);
        if (stream.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", stream.last_of_run, want.last_of_run);
        if (stream.end_of_image !== want.end_of_image)
            report_mismatch("end_of_image", stream.end_of_image, want.end_of_image);
    endtask

    // bytes leave before new pixels enter: a pixel's bytes pass the job queue and the output register first
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_width  = 1;
            reg_height = 1;
            cols_done  = 0;
            rows_done  = 0;
            due_q.delete();
            due_count  = 0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                check_byte();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_WIDTH)
                    reg_width = cfg.data;
                else if (cfg.index == CFG_HEIGHT)
                    reg_height = cfg.data;
            end
            if (pixels.valid && pixels.ready)
                encode_pixel(pixels.red, pixels.green, pixels.blue);
            due_count = due_q.size();
        end
    end

endmodule

// ===== bench/tb_bmp24_stream_writer.sv =====
// tb_bmp24_stream_writer: stimulus and verdict for the BMP stream writer;
// image sizes and pixels go in, the checker judges every byte out.
// Depends on bmpw_pkg, bmpw_if, bmpw_stream_checker and the block itself.

module tb_bmp24_stream_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import bmpw_pkg::*;

    // indexes outside the register map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int RANDOM_PIXELS = 300;
    localparam int FULL_SCALE    = 65536;
    localparam int LEVEL_MAX     = 131071;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   mismatches;
    int   bytes_due;
    int   pixels_sent = 0;
    int   reg_writes = 0;
    int   phases = 0;

    bmpw_pix_if  pix_ch ();
    bmpw_byte_if byte_ch ();
    bmpw_cfg_if  cfg_ch ();

    bmp24_stream_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_ch),
        .stream (byte_ch),
        .cfg    (cfg_ch)
    );

    bmpw_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pix_ch),
        .stream     (byte_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .bytes_due  (bytes_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("timed out with %0d bytes still due", bytes_due);
        $display("end of test: mismatches");
        $finish;
    end

    // byte sink: runs of ready broken by random stall bursts
    initial
    begin : sink_stalls
        int run_left;
        int stall_left;
        run_left = 0;
        stall_left = 0;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                byte_ch.ready <= 1'b1;
            else if (run_left > 0)
            begin
                run_left--;
                byte_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                byte_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                run_left = $urandom_range(0, 40);
                byte_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [VAL_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_W'(FULL_SCALE);
            2:       return VAL_W'(FULL_SCALE - 1);
            3:       return VAL_W'($urandom_range(FULL_SCALE + 1, LEVEL_MAX));
            4:       return VAL_W'($urandom_range(0, LEVEL_MAX));
            default: return VAL_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic int pick_dim();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIMENSION_DEF;
            3:       return MAX_DIMENSION_DEF + 1;
            default: return (1 << CFG_DATA_W) - 1;
        endcase
    endfunction

    // called and returns at a falling edge; valid stays high for a following pixel
    task automatic push_pixel(input logic [VAL_W-1:0] r, input logic [VAL_W-1:0] g,
                              input logic [VAL_W-1:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        forever
        begin
            @(posedge clk);
            if (pix_ch.ready)
                break;
        end
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        while (bytes_due != 0)
            @(negedge clk);
    endtask

    // sizes change only once every byte due has left
    task automatic configure(input bit set_w, input int w, input bit set_h, input int h);
        drain();
        if (set_w)
            write_reg(CFG_WIDTH, w);
        if (set_h)
            write_reg(CFG_HEIGHT, h);
        phases++;
    endtask

    task automatic run_phase(input bit set_w, input int w, input bit set_h, input int h,
                             input int count);
        configure(set_w, w, set_h, h);
        repeat (count)
            push_pixel(random_level(), random_level(), random_level());
        pix_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int first_random;
        int kind;
        int w;
        int h;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_WIDTH;
        cfg_ch.data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes, black, full scale, above full scale
        push_pixel('0, '0, '0);
        pix_ch.valid <= 1'b0;
        configure(1'b0, 0, 1'b0, 0);
        push_pixel(VAL_W'(FULL_SCALE), VAL_W'(FULL_SCALE), VAL_W'(FULL_SCALE));
        pix_ch.valid <= 1'b0;
        configure(1'b0, 0, 1'b0, 0);
        push_pixel(VAL_W'(LEVEL_MAX), VAL_W'(FULL_SCALE + 1), VAL_W'(FULL_SCALE - 1));
        pix_ch.valid <= 1'b0;

        // writes off the register map are ignored
        configure(1'b0, 0, 1'b0, 0);
        write_reg(CFG_SPARE_LO, $urandom_range(0, 8191));
        write_reg(CFG_SPARE_HI, $urandom_range(0, 8191));
        push_pixel(VAL_W'(1), VAL_W'(256), VAL_W'(32768));
        pix_ch.valid <= 1'b0;

        // zero sizes count as one; a small full frame with three pad bytes per row
        run_phase(1'b1, 0, 1'b1, 0, 1);
        run_phase(1'b1, 3, 1'b1, 2, 6);

        // sizes above the limit clamp; shrinking mid-frame closes the row or frame at once
        run_phase(1'b1, (1 << CFG_DATA_W) - 1, 1'b1, (1 << CFG_DATA_W) - 1, 1);
        run_phase(1'b1, 1, 1'b1, 1, 1);
        run_phase(1'b1, MAX_DIMENSION_DEF + 1, 1'b1, 2, 1);
        run_phase(1'b1, 1, 1'b0, 0, 2);
        run_phase(1'b1, 4, 1'b1, 3, 5);
        run_phase(1'b0, 0, 1'b1, 1, 3);

        first_random = pixels_sent;
        while (pixels_sent < first_random + RANDOM_PIXELS)
        begin
            if (pixels_sent >= first_random + RANDOM_PIXELS * 17 / 20)
                calm = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                w = pick_dim();
                h = pick_dim();
                run_phase(1'b1, w, 1'b1, h, (w * h <= 48) ? w * h : w);
            end
            else if (kind <= 8)
            begin
                // one size changed, pixel count unrelated to the frame
                if ($urandom_range(0, 1) == 1)
                    run_phase(1'b1, pick_dim(), 1'b0, 0, $urandom_range(1, 12));
                else
                    run_phase(1'b0, 0, 1'b1, pick_dim(), $urandom_range(1, 12));
            end
            else
                run_phase(1'b1, pick_extreme(), 1'b1, pick_extreme(), $urandom_range(1, 3));
        end

        drain();
        repeat (8) @(negedge clk);
        $display("%0d pixels in %0d size phases, %0d register writes", pixels_sent, phases,
                 reg_writes);
        $display("sizes from 0 to 8191 with mid-frame changes, levels past full scale");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
